/* design/cts_pkg.sv */
// Package: item types and constants for the CAN transport segmenter.
`timescale 1ns / 1ps
package cts_pkg;

   localparam logic [11:0] MAX_MESSAGE_LENGTH = 12'd4095;

   localparam logic       OP_START   = 1'b0;
   localparam logic       OP_PAYLOAD = 1'b1;

   localparam logic       STATUS_OK     = 1'b0;
   localparam logic       STATUS_REJECT = 1'b1;

   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_FIRST  = 2'd1;
   localparam logic [1:0] KIND_CONSEC = 2'd2;

   localparam logic [3:0] FF_PCI_NIBBLE = 4'h1;
   localparam logic [3:0] CF_PCI_NIBBLE = 4'h2;
   localparam logic [3:0] SF_LIMIT      = 4'd8;
   localparam logic [3:0] FRAME_BYTES   = 4'd8;

   typedef struct packed {
      logic        opcode;
      logic [11:0] message_length;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [63:0] frame_bytes;
      logic [3:0]  frame_length;
      logic [1:0]  frame_kind;
      logic        await_flow_control;
      logic        message_done;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } cts_result_type;

endpackage

/* design/can_transport_segmenter.sv */
// Top level: input register, frame builder and result register.
// An accepted item's result, if any, goes through the result register to rsp_.
// Throughput: one item per cycle unless stalled; state updates as items advance.
// A held result stalls the input register only while rsp_stall is high.
// Reset (synchronous, active high) empties both registers and idles the
// segmenter with the sequence nibble at 1.
`timescale 1ns / 1ps
module can_transport_segmenter import cts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic           in_valid_ff;
   req_item_type   in_item_ff;
   logic           out_valid_ff;
   rsp_item_type   out_item_ff;
   logic           out_free;
   logic           advance;
   cts_result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   cts_frame_builder u_builder (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) begin
         out_item_ff <= result.item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

`ifndef SYNTHESIS
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_REJECT |->
         rsp_item.frame_length == 4'd0 && rsp_item.frame_bytes == 64'd0)
      else $error("rejected length result carries frame data");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_OK |->
         rsp_item.frame_length != 4'd0 && rsp_item.frame_length <= FRAME_BYTES)
      else $error("frame length out of range");

   a_first_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.await_flow_control |->
         rsp_item.frame_kind == KIND_FIRST && rsp_item.frame_length == FRAME_BYTES)
      else $error("flow control flag on a frame that is not a full first frame");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled without a held item and result");
`endif

endmodule

/* design/cts_frame_builder.sv */
// Segmentation state and per-item frame building logic.
`timescale 1ns / 1ps
module cts_frame_builder import cts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_item_type   item,
   output cts_result_type result
);

   logic [11:0] bytes_left_ff, bytes_left_in;
   logic        multi_mode_ff, multi_mode_in;
   logic        first_pending_ff, first_pending_in;
   logic [3:0]  sequence_ff, sequence_in;
   logic [63:0] buffer_ff, buffer_in;
   logic [3:0]  fill_ff, fill_in;

   logic [63:0] buffer_put;
   logic [3:0]  fill_put;
   logic [11:0] left_dec;
   logic        len_bad;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         buffer_put[8*i +: 8] = (fill_ff[2:0] == 3'(i)) ? item.data_byte
                                                        : buffer_ff[8*i +: 8];
      end
   end

   assign fill_put = fill_ff + 4'd1;
   assign left_dec = bytes_left_ff - 12'd1;
   assign len_bad  = (item.message_length == 12'd0) ||
                     (item.message_length > MAX_MESSAGE_LENGTH);

   always_comb begin
      bytes_left_in    = bytes_left_ff;
      multi_mode_in    = multi_mode_ff;
      first_pending_in = first_pending_ff;
      sequence_in      = sequence_ff;
      buffer_in        = buffer_ff;
      fill_in          = fill_ff;
      result           = '0;
      if (item.opcode == OP_START) begin
         buffer_in   = '0;
         fill_in     = '0;
         sequence_in = 4'd1;
         if (len_bad) begin
            bytes_left_in    = '0;
            multi_mode_in    = 1'b0;
            first_pending_in = 1'b0;
            result.valid       = 1'b1;
            result.item.status = STATUS_REJECT;
         end else begin
            bytes_left_in = item.message_length;
            if (item.message_length < 12'(SF_LIMIT)) begin
               multi_mode_in    = 1'b0;
               first_pending_in = 1'b0;
               buffer_in[7:0]   = item.message_length[7:0];
               fill_in          = 4'd1;
            end else begin
               multi_mode_in    = 1'b1;
               first_pending_in = 1'b1;
               buffer_in[7:0]   = {FF_PCI_NIBBLE, item.message_length[11:8]};
               buffer_in[15:8]  = item.message_length[7:0];
               fill_in          = 4'd2;
            end
         end
      end else if (bytes_left_ff != 12'd0) begin
         bytes_left_in = left_dec;
         buffer_in     = buffer_put;
         fill_in       = fill_put;
         if (fill_put >= FRAME_BYTES || left_dec == 12'd0) begin
            result.valid                   = 1'b1;
            result.item.status             = STATUS_OK;
            result.item.frame_bytes        = buffer_put;
            result.item.frame_length       = fill_put;
            result.item.message_done       = (left_dec == 12'd0);
            if (!multi_mode_ff) begin
               result.item.frame_kind = KIND_SINGLE;
            end else if (first_pending_ff) begin
               result.item.frame_kind         = KIND_FIRST;
               result.item.await_flow_control = 1'b1;
            end else begin
               result.item.frame_kind = KIND_CONSEC;
            end
            first_pending_in = 1'b0;
            buffer_in        = '0;
            if (left_dec == 12'd0) begin
               fill_in       = '0;
               multi_mode_in = 1'b0;
               sequence_in   = 4'd1;
            end else begin
               buffer_in[7:0] = {CF_PCI_NIBBLE, sequence_ff};
               fill_in        = 4'd1;
               sequence_in    = sequence_ff + 4'd1;
            end
         end
      end
      if (!fire) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= '0;
         multi_mode_ff    <= 1'b0;
         first_pending_ff <= 1'b0;
         sequence_ff      <= 4'd1;
         buffer_ff        <= '0;
         fill_ff          <= '0;
      end else if (fire) begin
         bytes_left_ff    <= bytes_left_in;
         multi_mode_ff    <= multi_mode_in;
         first_pending_ff <= first_pending_in;
         sequence_ff      <= sequence_in;
         buffer_ff        <= buffer_in;
         fill_ff          <= fill_in;
      end
   end

endmodule
